@@ design/vsa_pkg.sv @@
// ----------------------------------------------------------------------------
// vsa_pkg
// Types, command codes and matrix coefficients shared by the vectorscope
// accumulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vsa_pkg;

  typedef enum logic [1:0] {
    CMD_ACCUM      = 2'd0,
    CMD_READ       = 2'd1,
    CMD_READ_CLEAR = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_ROUND,
    ST_INDEX,
    ST_READ,
    ST_UPDATE
  } state_t;

  localparam int COEF_BITS   = 18;
  localparam int SAMPLE_BITS = 16;
  localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
  localparam int FRAC_BITS   = 28;

  // Multiply steps: 0..2 build Cb, 3..5 build -Cr; step 6 only drains.
  localparam logic [2:0] STEP_FIRST_ROW = 3'd3;
  localparam logic [2:0] STEP_LAST      = 3'd6;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       acc_en;
    logic [2:0] step;
    logic       scale_en;
    logic       round_en;
    logic       index_en;
    logic       rd_en;
    logic       wr_en;
    logic       wr_inc;
    logic       sweep;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic idx_ok;
    logic out_free;
    logic clear_last;
  } ctrl_stat_t;

  // Cb row, then negated Cr row, Q0.16.
  function automatic coef_t coef(input logic [2:0] step);
    coef_t c;
    unique case (step)
      3'd0:    c = -18'sd7509;
      3'd1:    c = -18'sd25259;
      3'd2:    c = 18'sd32768;
      3'd3:    c = -18'sd32768;
      3'd4:    c = 18'sd29763;
      3'd5:    c = 18'sd3005;
      default: c = 18'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/vectorscope_accumulate.sv @@
// ----------------------------------------------------------------------------
// vectorscope_accumulate
// Two-dimensional BT.709 chroma histogram of an RGB pixel stream, with bin
// read and read-and-clear commands.
// ----------------------------------------------------------------------------
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   input   | in_valid, in_stall  | command, red, green, blue, bin_index
//   output  | out_valid, out_stall| bin_count
//
// Accumulate beat: six steps of one shared multiplier, then scaling, rounding,
// address and a read-modify-write of the count RAM.
// Read beat: RAM read, then result load; command 3 only returns to idle.
// After reset a sweep zeroes all GRID_SIZE*GRID_SIZE RAM words, in_stall high.
// A result waits in the output register; out_stall only holds off the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module vectorscope_accumulate #(
  parameter int GRID_SIZE  = 256,
  parameter int COUNT_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic signed [15:0] red,
  input  wire logic signed [15:0] green,
  input  wire logic signed [15:0] blue,
  input  wire logic [15:0]        bin_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             bin_count
);

  vsa_pkg::ctrl_cmd_t  ctl;
  vsa_pkg::ctrl_stat_t stat;

  vsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .ctl      (ctl)
  );

  vsa_datapath #(
    .GRID_SIZE  (GRID_SIZE),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .command   (command),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .bin_index (bin_index),
    .bin_count (bin_count),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

@@ design/vsa_ram.sv @@
// ----------------------------------------------------------------------------
// vsa_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/vsa_datapath.sv @@
// ----------------------------------------------------------------------------
// vsa_datapath
// Chroma matrix with one shared multiplier, grid scaling and rounding, bin
// address, count store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vsa_datapath #(
  parameter int GRID_SIZE  = 256,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire vsa_pkg::ctrl_cmd_t        ctl,
  output vsa_pkg::ctrl_stat_t            stat,
  input  wire logic [1:0]                command,
  input  wire logic signed [15:0]        red,
  input  wire logic signed [15:0]        green,
  input  wire logic signed [15:0]        blue,
  input  wire logic [15:0]               bin_index,
  output logic [31:0]                    bin_count,
  output logic                           out_valid,
  input  wire logic                      out_stall
);

  localparam int BIN_TOTAL = GRID_SIZE * GRID_SIZE;
  localparam int AW        = $clog2(BIN_TOTAL);
  localparam int IW        = (AW > 16) ? AW : 16;
  localparam int GB        = $clog2(GRID_SIZE);
  localparam int PB        = vsa_pkg::PROD_BITS;
  localparam int PW        = PB + GB + 2;
  localparam int RW        = PW - vsa_pkg::FRAC_BITS;

  localparam logic signed [PW-1:0] GRID_S = PW'(GRID_SIZE);
  localparam logic signed [PW-1:0] OFFSET = PW'(GRID_SIZE - 1) << (vsa_pkg::FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HALF   = PW'(1) << (vsa_pkg::FRAC_BITS - 1);
  localparam logic [RW-1:0]        R_MAX  = RW'(GRID_SIZE - 1);
  localparam logic [31:0]          TOTAL  = 32'(BIN_TOTAL);
  localparam logic [AW-1:0]        A_LAST = AW'(BIN_TOTAL - 1);

  vsa_pkg::cmd_t           cmd_r;
  logic signed [15:0]      red_r, green_r, blue_r;
  logic [15:0]             bin_r;
  logic signed [15:0]      sample;
  logic signed [PB-1:0]    prod;
  logic                    prod_row;
  logic signed [PB-1:0]    acc_cb, acc_row;
  logic signed [PW-1:0]    pos_cb, pos_row;
  logic [GB-1:0]           col, row;
  logic [AW-1:0]           pix_addr, bin_addr, sweep_addr, rd_addr, wr_addr;
  logic [IW-1:0]           bin_ext;
  logic [COUNT_BITS-1:0]   rd_data, wr_data;

  function automatic logic [GB-1:0] to_grid(input logic signed [PW-1:0] pos);
    logic signed [PW-1:0] t;
    logic [RW-1:0]        r;
    t = pos + HALF;
    r = t[PW-1:vsa_pkg::FRAC_BITS];
    if (pos[PW-1]) begin
      return '0;
    end else if (r > R_MAX) begin
      return GB'(GRID_SIZE - 1);
    end
    return r[GB-1:0];
  endfunction

  always_comb begin
    unique case (ctl.step) inside
      3'd0, 3'd3: sample = red_r;
      3'd1, 3'd4: sample = green_r;
      default:    sample = blue_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= vsa_pkg::cmd_t'(command);
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      bin_r   <= bin_index;
      acc_cb  <= '0;
      acc_row <= '0;
    end
    if (ctl.mul_en) begin
      prod     <= sample * vsa_pkg::coef(ctl.step);
      prod_row <= (ctl.step >= vsa_pkg::STEP_FIRST_ROW);
    end
    if (ctl.acc_en) begin
      if (prod_row) begin
        acc_row <= acc_row + prod;
      end else begin
        acc_cb <= acc_cb + prod;
      end
    end
    if (ctl.scale_en) begin
      pos_cb  <= PW'(acc_cb) * GRID_S + OFFSET;
      pos_row <= PW'(acc_row) * GRID_S + OFFSET;
    end
    if (ctl.round_en) begin
      col <= to_grid(pos_cb);
      row <= to_grid(pos_row);
    end
    if (ctl.index_en) begin
      pix_addr <= AW'(row) * AW'(GRID_SIZE) + AW'(col);
    end
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (ctl.sweep && ctl.wr_en) begin
      sweep_addr <= sweep_addr + AW'(1);
    end
  end

  assign bin_ext  = IW'(bin_r);
  assign bin_addr = bin_ext[AW-1:0];
  assign rd_addr  = (cmd_r == vsa_pkg::CMD_ACCUM) ? pix_addr : bin_addr;

  always_comb begin
    if (ctl.sweep) begin
      wr_addr = sweep_addr;
    end else if (cmd_r == vsa_pkg::CMD_ACCUM) begin
      wr_addr = pix_addr;
    end else begin
      wr_addr = bin_addr;
    end
  end

  assign wr_data = !ctl.wr_inc ? '0 :
                   (&rd_data)  ? rd_data : rd_data + COUNT_BITS'(1);

  vsa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_TOTAL)
  ) u_store (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      bin_count <= stat.idx_ok ? 32'(rd_data) : 32'd0;
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.idx_ok     = ({16'd0, bin_r} < TOTAL);
  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.clear_last = (sweep_addr == A_LAST);

endmodule

`default_nettype wire

@@ design/vsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// vsa_ctrl
// Sequencer for the vectorscope accumulator: clear sweep, multiply steps,
// scaling, bin lookup and store update.
// ----------------------------------------------------------------------------
`default_nettype none

module vsa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          command,
  input  wire vsa_pkg::ctrl_stat_t stat,
  output vsa_pkg::ctrl_cmd_t       ctl
);

  vsa_pkg::state_t state, state_next;
  logic [2:0]      step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsa_pkg::ST_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    ctl        = '0;
    ctl.step   = step;
    in_stall   = 1'b1;
    unique case (state)
      vsa_pkg::ST_CLEAR: begin
        ctl.sweep  = 1'b1;
        ctl.wr_en  = 1'b1;
        if (stat.clear_last) begin
          state_next = vsa_pkg::ST_IDLE;
        end
      end
      vsa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load  = 1'b1;
          step_next = '0;
          unique case (vsa_pkg::cmd_t'(command)) inside
            vsa_pkg::CMD_ACCUM:                          state_next = vsa_pkg::ST_MUL;
            vsa_pkg::CMD_READ, vsa_pkg::CMD_READ_CLEAR:  state_next = vsa_pkg::ST_READ;
            vsa_pkg::CMD_NONE:                           state_next = vsa_pkg::ST_IDLE;
          endcase
        end
      end
      vsa_pkg::ST_MUL: begin
        ctl.mul_en = (step != vsa_pkg::STEP_LAST);
        ctl.acc_en = (step != 3'd0);
        step_next  = step + 3'd1;
        if (step == vsa_pkg::STEP_LAST) begin
          state_next = vsa_pkg::ST_SCALE;
        end
      end
      vsa_pkg::ST_SCALE: begin
        ctl.scale_en = 1'b1;
        state_next   = vsa_pkg::ST_ROUND;
      end
      vsa_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
        state_next   = vsa_pkg::ST_INDEX;
      end
      vsa_pkg::ST_INDEX: begin
        ctl.index_en = 1'b1;
        state_next   = vsa_pkg::ST_READ;
      end
      vsa_pkg::ST_READ: begin
        ctl.rd_en  = 1'b1;
        state_next = vsa_pkg::ST_UPDATE;
      end
      vsa_pkg::ST_UPDATE: begin
        if (stat.cmd == vsa_pkg::CMD_ACCUM) begin
          ctl.wr_en  = 1'b1;
          ctl.wr_inc = 1'b1;
          state_next = vsa_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          ctl.out_load = 1'b1;
          ctl.wr_en    = (stat.cmd == vsa_pkg::CMD_READ_CLEAR) && stat.idx_ok;
          state_next   = vsa_pkg::ST_IDLE;
        end
      end
      default: state_next = vsa_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the vectorscope accumulator against an in-bench chroma histogram.
// A short table of directed beats is followed by random pixel streams and
// bin reads, with random idling on the input side and random output stalls.
// Every read result is compared in order with the predicted bin count.
// ----------------------------------------------------------------------------

module testbench;

  localparam int      GRID      = 256;
  localparam int      BIN_TOTAL = GRID * GRID;
  localparam logic [15:0] GRAY_BIN = 16'((GRID / 2) * GRID + GRID / 2);
  localparam int      RANDOM_BEATS = 450;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  // BT.709 chroma rows, Q0.16
  localparam longint CB_R = -7509;
  localparam longint CB_G = -25259;
  localparam longint CB_B = 32768;
  localparam longint CR_R = 32768;
  localparam longint CR_G = -29763;
  localparam longint CR_B = -3005;
  localparam longint HALF_Q28 = 64'sd1 <<< 27;

  typedef struct {
    vsa_pkg::cmd_t      cmd;
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic [15:0]        bin_index;
    bit                 at_last_pixel;
    bit                 typed;
    logic [31:0]        count;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = vsa_pkg::CMD_NONE;
  logic signed [15:0] red = '0;
  logic signed [15:0] green = '0;
  logic signed [15:0] blue = '0;
  logic [15:0]        bin_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        bin_count;

  bit          idle_on = 1'b1;
  int          mismatches = 0;
  int          last_pixel_bin = 0;
  logic [31:0] bin_counts [BIN_TOTAL];
  logic [31:0] pending_counts [$];
  int          hit_bins [$];
  logic signed [15:0] palette_red [4];
  logic signed [15:0] palette_green [4];
  logic signed [15:0] palette_blue [4];

  stim_row_t directed [24] = '{
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b0, 1'b1, 32'd0},
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b0, 1'b1, 32'd0},
    '{vsa_pkg::CMD_READ_CLEAR, 16'sd0, 16'sd0, 16'sd0, GRAY_BIN, 1'b0, 1'b1, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      S_MAX,  S_MAX,  S_MAX,  16'hFFFF, 1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      S_MIN,  S_MIN,  S_MIN,  16'h5A5A, 1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ,       -16'sd1, -16'sd1, -16'sd1, GRAY_BIN, 1'b0, 1'b1, 32'd3},
    '{vsa_pkg::CMD_ACCUM,      S_MAX,  16'sd0, 16'sd0, 16'd0,    1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b1, 1'b0, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      S_MIN,  16'sd0, 16'sd0, 16'd0,    1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b1, 1'b0, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      16'sd0, S_MAX,  16'sd0, 16'd0,    1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      16'sd0, S_MAX,  16'sd0, 16'd0,    1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b1, 1'b0, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      16'sd0, S_MIN,  16'sd0, 16'd0,    1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b1, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b1, 1'b1, 32'd0},
    '{vsa_pkg::CMD_NONE,       -16'sd1, -16'sd1, -16'sd1, GRAY_BIN, 1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ_CLEAR, 16'sd0, 16'sd0, 16'sd0, GRAY_BIN, 1'b0, 1'b1, 32'd3},
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, GRAY_BIN, 1'b0, 1'b1, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      16'sd0, 16'sd0, 16'sd32, 16'd0,   1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b1, 1'b0, 32'd0},
    '{vsa_pkg::CMD_ACCUM,      16'sd0, 16'sd0, -16'sd32, 16'd0,  1'b0, 1'b0, 32'd0},
    '{vsa_pkg::CMD_READ,       16'sd0, 16'sd0, 16'sd0, 16'd0,    1'b1, 1'b0, 32'd0}
  };

  vectorscope_accumulate #(
    .GRID_SIZE  (GRID),
    .COUNT_BITS (32)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .bin_index (bin_index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bin_count (bin_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Q.28 chroma to grid coordinate, half away from zero, clamped
  function automatic int grid_coord(input longint v28);
    longint pos;
    longint q;
    pos = v28 * GRID + longint'(GRID - 1) * HALF_Q28;
    if (pos >= 0) begin
      q = (pos + HALF_Q28) >>> 28;
    end else begin
      q = -((-pos + HALF_Q28) >>> 28);
    end
    if (q < 0) begin
      q = 0;
    end else if (q > GRID - 1) begin
      q = GRID - 1;
    end
    return int'(q);
  endfunction

  function automatic int pixel_bin(input logic signed [15:0] r, g, b);
    longint rl;
    longint gl;
    longint bl;
    longint cb;
    longint cr;
    rl = r;
    gl = g;
    bl = b;
    cb = CB_R * rl + CB_G * gl + CB_B * bl;
    cr = CR_R * rl + CR_G * gl + CR_B * bl;
    return grid_coord(-cr) * GRID + grid_coord(cb);
  endfunction

  // Updates the histogram mirror; returns the count a read would see
  function automatic logic [31:0] histogram_step(input vsa_pkg::cmd_t c,
                                                 input logic signed [15:0] r, g, b,
                                                 input logic [15:0] idx);
    logic [31:0] seen;
    int bin;
    seen = '0;
    case (c) inside
      vsa_pkg::CMD_ACCUM: begin
        bin = pixel_bin(r, g, b);
        if (bin_counts[bin] != COUNT_MAX) begin
          bin_counts[bin] = bin_counts[bin] + 32'd1;
        end
        last_pixel_bin = bin;
        hit_bins.push_back(bin);
        if (hit_bins.size() > 64) begin
          void'(hit_bins.pop_front());
        end
      end
      vsa_pkg::CMD_READ, vsa_pkg::CMD_READ_CLEAR: begin
        if (int'(idx) < BIN_TOTAL) begin
          seen = bin_counts[idx];
          if (c == vsa_pkg::CMD_READ_CLEAR) begin
            bin_counts[idx] = '0;
          end
        end
      end
      default: ;
    endcase
    return seen;
  endfunction

  task automatic send_beat(input vsa_pkg::cmd_t c, input logic signed [15:0] r, g, b,
                           input logic [15:0] idx, input bit typed,
                           input logic [31:0] typed_count);
    logic [31:0] seen;
    while (idle_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= c;
    red       <= r;
    green     <= g;
    blue      <= b;
    bin_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    seen = histogram_step(c, r, g, b, idx);
    if (c == vsa_pkg::CMD_READ || c == vsa_pkg::CMD_READ_CLEAR) begin
      pending_counts.push_back(typed ? typed_count : seen);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_counts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, got bin_count %0d", $time, bin_count);
      end else begin
        want = pending_counts.pop_front();
        if (bin_count !== want) begin
          mismatches++;
          $display("%0t: bin_count expected %0d, got %0d", $time, want, bin_count);
        end
      end
    end
  end

  initial begin
    stim_row_t          row;
    vsa_pkg::cmd_t      c;
    logic signed [15:0] r;
    logic signed [15:0] g;
    logic signed [15:0] b;
    logic [15:0]        idx;
    int                 sel;
    int                 pick;
    int                 beats_done;

    foreach (bin_counts[i]) bin_counts[i] = '0;
    for (int i = 0; i < 4; i++) begin
      palette_red[i]   = 16'($urandom_range(8192)) - 16'sd4096;
      palette_green[i] = 16'($urandom_range(8192)) - 16'sd4096;
      palette_blue[i]  = 16'($urandom_range(8192)) - 16'sd4096;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      row = directed[i];
      idx = row.at_last_pixel ? 16'(last_pixel_bin) : row.bin_index;
      send_beat(row.cmd, row.red, row.green, row.blue, idx, row.typed, row.count);
    end

    beats_done = 0;
    while (beats_done < RANDOM_BEATS) begin
      if (beats_done == 150) idle_on <= 1'b0;
      if (beats_done == 260) idle_on <= 1'b1;
      sel = $urandom_range(99);
      r   = 16'($urandom);
      g   = 16'($urandom);
      b   = 16'($urandom);
      idx = 16'($urandom);
      if (sel < 55) begin
        c = vsa_pkg::CMD_ACCUM;
        pick = $urandom_range(9);
        if (pick < 4) begin
          pick = $urandom_range(3);
          r = palette_red[pick];
          g = palette_green[pick];
          b = palette_blue[pick];
        end else if (pick < 7) begin
          r = 16'($urandom_range(8192)) - 16'sd4096;
          g = 16'($urandom_range(8192)) - 16'sd4096;
          b = 16'($urandom_range(8192)) - 16'sd4096;
        end
      end else if (sel < 95) begin
        if (sel < 77) begin
          c = vsa_pkg::CMD_READ;
        end else begin
          c = vsa_pkg::CMD_READ_CLEAR;
        end
        if (hit_bins.size() > 0 && $urandom_range(9) < 8) begin
          idx = 16'(hit_bins[$urandom_range(hit_bins.size() - 1)]);
        end
      end else begin
        c = vsa_pkg::CMD_NONE;
      end
      send_beat(c, r, g, b, idx, 1'b0, '0);
      if (c != vsa_pkg::CMD_NONE) beats_done++;
    end
    in_valid <= 1'b0;

    while (pending_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
